### rtl/core/arpr_pkg.sv
// ----------------------------------------------------------------------------
// arpr_pkg
// Shared types and codes of the single-entry ARP resolver: classified item
// record, entry modes, result event codes and send kinds.
// ----------------------------------------------------------------------------
package arpr_pkg;

   // classification made by the front end
   typedef enum logic [2:0] {
      OP_SHORT,
      OP_MALFORMED,
      OP_NOT_US,
      OP_LEARN_REQ,
      OP_LEARN_REP,
      OP_QUERY,
      OP_TICK,
      OP_NONE
   } op_type;

   // state of the single cache entry
   typedef enum logic [1:0] {
      MODE_FREE,
      MODE_VALID,
      MODE_PENDING
   } mode_type;

   // input action codes
   localparam logic [1:0] ACT_FRAME = 2'd0;
   localparam logic [1:0] ACT_QUERY = 2'd1;
   localparam logic [1:0] ACT_TICK  = 2'd2;

   // ARP header values that a frame must carry
   localparam logic [10:0] MIN_FRAME_LEN = 11'd28;
   localparam logic [15:0] HTYPE_ETH     = 16'h0001;
   localparam logic [15:0] PTYPE_IPV4    = 16'h0800;
   localparam logic [7:0]  HLEN_ETH      = 8'd6;
   localparam logic [7:0]  PLEN_IPV4     = 8'd4;
   localparam logic [15:0] ARP_OP_REQ    = 16'd1;
   localparam logic [15:0] ARP_OP_REP    = 16'd2;

   // frame to send
   localparam logic [1:0] KIND_NONE  = 2'd0;
   localparam logic [1:0] KIND_BCAST = 2'd1;
   localparam logic [1:0] KIND_REPLY = 2'd2;

   // result events
   localparam logic [3:0] EV_SHORT     = 4'd0;
   localparam logic [3:0] EV_MALFORMED = 4'd1;
   localparam logic [3:0] EV_NOT_US    = 4'd2;
   localparam logic [3:0] EV_LEARN_REQ = 4'd3;
   localparam logic [3:0] EV_LEARN_REP = 4'd4;
   localparam logic [3:0] EV_HIT       = 4'd5;
   localparam logic [3:0] EV_MISS      = 4'd6;
   localparam logic [3:0] EV_QUIET     = 4'd7;
   localparam logic [3:0] EV_EXPIRED   = 4'd8;
   localparam logic [3:0] EV_RETRY     = 4'd9;
   localparam logic [3:0] EV_FREED     = 4'd10;

   // configuration register indexes
   localparam logic [2:0] REG_LOCAL_IP    = 3'd0;
   localparam logic [2:0] REG_LOCAL_MAC   = 3'd1;
   localparam logic [2:0] REG_VALID_TO    = 3'd2;
   localparam logic [2:0] REG_PENDING_TO  = 3'd3;
   localparam logic [2:0] REG_MAX_RETRIES = 3'd4;

   // classified item passed from front to back
   typedef struct packed {
      op_type      op;
      logic [31:0] ip;
      logic [47:0] mac;
   } item_type;

   // aging settings used by the back end
   typedef struct packed {
      logic [15:0] valid_to;
      logic [15:0] pending_to;
      logic [7:0]  max_retries;
   } timing_type;

   // back end status seen at the top level
   typedef struct packed {
      logic     pop;
      mode_type mode;
   } back_status_type;

endpackage

### rtl/core/arpr_front.sv
// ----------------------------------------------------------------------------
// arpr_front
// Classifies an incoming item: frame checks against the ARP header rules and
// the local IP, resolve queries and timer ticks, into a compact record.
// ----------------------------------------------------------------------------
module arpr_front (
   input  logic [1:0]       action,
   input  logic [10:0]      frame_length,
   input  logic [15:0]      hardware_type,
   input  logic [15:0]      protocol_type,
   input  logic [7:0]       hardware_len,
   input  logic [7:0]       protocol_len,
   input  logic [15:0]      arp_opcode,
   input  logic [47:0]      src_mac,
   input  logic [31:0]      src_ip,
   input  logic [31:0]      dst_ip,
   input  logic [31:0]      query_ip,
   input  logic [31:0]      local_ip,
   output arpr_pkg::item_type item
);
   import arpr_pkg::*;

   logic hdr_ok;

   // header sanity checks
   assign hdr_ok = (hardware_type == HTYPE_ETH) && (protocol_type == PTYPE_IPV4) &&
                   (hardware_len == HLEN_ETH) && (protocol_len == PLEN_IPV4) &&
                   ((arp_opcode == ARP_OP_REQ) || (arp_opcode == ARP_OP_REP));

   // classify the item
   always_comb begin
      item.ip  = src_ip;
      item.mac = src_mac;
      case (action)
         ACT_FRAME: begin
            if (frame_length < MIN_FRAME_LEN) begin
               item.op = OP_SHORT;
            end else if (!hdr_ok) begin
               item.op = OP_MALFORMED;
            end else if (dst_ip != local_ip) begin
               item.op = OP_NOT_US;
            end else if (arp_opcode == ARP_OP_REQ) begin
               item.op = OP_LEARN_REQ;
            end else begin
               item.op = OP_LEARN_REP;
            end
         end
         ACT_QUERY: begin
            item.op = OP_QUERY;
            item.ip = query_ip;
         end
         ACT_TICK: begin
            item.op = OP_TICK;
         end
         default: begin
            item.op = OP_NONE;
         end
      endcase
   end

endmodule

### rtl/core/arpr_queue.sv
// ----------------------------------------------------------------------------
// arpr_queue
// Short register queue of classified items between front and back end.
// ----------------------------------------------------------------------------
module arpr_queue #(
   parameter int DEPTH = 2
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  arpr_pkg::item_type push_item,
   output logic               push_ready,
   input  logic               pop,
   output arpr_pkg::item_type pop_item,
   output logic               pop_valid
);
   import arpr_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   item_type          slot_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              do_push, do_pop;

   assign push_ready = (count_ff != FULL_CNT);
   assign pop_valid  = (count_ff != '0);
   assign pop_item   = slot_ff[rd_ptr_ff];
   assign do_push    = push && push_ready;
   assign do_pop     = pop && pop_valid;

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

### rtl/core/arpr_back.sv
// ----------------------------------------------------------------------------
// arpr_back
// Carries out classified items against the single cache entry: learning,
// lookups and tick aging, and holds the result in an output register.
// ----------------------------------------------------------------------------
module arpr_back (
   input  logic                      clock,
   input  logic                      reset,
   input  arpr_pkg::item_type        item,
   input  logic                      item_valid,
   output logic                      item_pop,
   input  arpr_pkg::timing_type      timing,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [1:0]                rsp_kind,
   output logic [31:0]               rsp_dst_ip,
   output logic [47:0]               rsp_dst_mac,
   output logic                      rsp_hit,
   output logic [47:0]               rsp_resolved_mac,
   output logic [3:0]                rsp_event,
   output arpr_pkg::back_status_type status
);
   import arpr_pkg::*;

   // entry state
   mode_type    mode_ff, mode_in;
   logic [31:0] ip_ff, ip_in;
   logic [47:0] mac_ff, mac_in;
   logic [15:0] ticks_ff, ticks_in;
   logic [7:0]  retries_ff, retries_in;

   // result register
   logic        valid_ff;
   logic [1:0]  kind_ff, kind_in;
   logic [31:0] tip_ff, tip_in;
   logic [47:0] tmac_ff, tmac_in;
   logic        hit_ff, hit_in;
   logic [47:0] rmac_ff, rmac_in;
   logic [3:0]  event_ff, event_in;

   logic        expire;

   assign item_pop = item_valid && (!valid_ff || rsp_ready);
   assign expire   = (ticks_ff[15:1] == 15'd0);

   // execute the head item
   always_comb begin
      mode_in    = mode_ff;
      ip_in      = ip_ff;
      mac_in     = mac_ff;
      ticks_in   = ticks_ff;
      retries_in = retries_ff;
      kind_in    = KIND_NONE;
      tip_in     = '0;
      tmac_in    = '0;
      hit_in     = 1'b0;
      rmac_in    = '0;
      event_in   = EV_QUIET;
      case (item.op)
         OP_SHORT:     event_in = EV_SHORT;
         OP_MALFORMED: event_in = EV_MALFORMED;
         OP_NOT_US:    event_in = EV_NOT_US;
         OP_LEARN_REQ, OP_LEARN_REP: begin
            mode_in    = MODE_VALID;
            ip_in      = item.ip;
            mac_in     = item.mac;
            ticks_in   = timing.valid_to;
            retries_in = timing.max_retries;
            if (item.op == OP_LEARN_REQ) begin
               kind_in  = KIND_REPLY;
               tip_in   = item.ip;
               tmac_in  = item.mac;
               event_in = EV_LEARN_REQ;
            end else begin
               event_in = EV_LEARN_REP;
            end
         end
         OP_QUERY: begin
            if ((mode_ff == MODE_VALID) && (ip_ff == item.ip)) begin
               hit_in   = 1'b1;
               rmac_in  = mac_ff;
               event_in = EV_HIT;
            end else begin
               kind_in  = KIND_BCAST;
               tip_in   = item.ip;
               event_in = EV_MISS;
            end
         end
         OP_TICK: begin
            case (mode_ff)
               MODE_VALID: begin
                  if (expire) begin
                     kind_in  = KIND_BCAST;
                     tip_in   = ip_ff;
                     mode_in  = MODE_PENDING;
                     ticks_in = timing.pending_to;
                     event_in = EV_EXPIRED;
                  end else begin
                     ticks_in = ticks_ff - 16'd1;
                  end
               end
               MODE_PENDING: begin
                  if (!expire) begin
                     ticks_in = ticks_ff - 16'd1;
                  end else if (retries_ff == 8'd0) begin
                     mode_in  = MODE_FREE;
                     ticks_in = '0;
                     event_in = EV_FREED;
                  end else begin
                     retries_in = retries_ff - 8'd1;
                     kind_in    = KIND_BCAST;
                     tip_in     = ip_ff;
                     ticks_in   = timing.pending_to;
                     event_in   = EV_RETRY;
                  end
               end
               default: begin
               end
            endcase
         end
         default: event_in = EV_QUIET;
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_FREE;
         valid_ff <= 1'b0;
      end else begin
         if (item_pop) begin
            mode_ff <= mode_in;
         end
         if (item_pop) begin
            valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            valid_ff <= 1'b0;
         end
      end
   end

   // entry payload and result payload
   always_ff @(posedge clock) begin
      if (item_pop) begin
         ip_ff      <= ip_in;
         mac_ff     <= mac_in;
         ticks_ff   <= ticks_in;
         retries_ff <= retries_in;
         kind_ff    <= kind_in;
         tip_ff     <= tip_in;
         tmac_ff    <= tmac_in;
         hit_ff     <= hit_in;
         rmac_ff    <= rmac_in;
         event_ff   <= event_in;
      end
   end

   assign rsp_valid        = valid_ff;
   assign rsp_kind         = kind_ff;
   assign rsp_dst_ip       = tip_ff;
   assign rsp_dst_mac      = tmac_ff;
   assign rsp_hit          = hit_ff;
   assign rsp_resolved_mac = rmac_ff;
   assign rsp_event        = event_ff;
   assign status.pop       = item_pop;
   assign status.mode      = mode_ff;

endmodule

### rtl/core/arp_single_entry_resolver.sv
// ----------------------------------------------------------------------------
// arp_single_entry_resolver
// Single-entry ARP cache with refresh, retry and timeout.
// ----------------------------------------------------------------------------
// Usage:
//   req_* is the item stream: tuser carries the action (frame, query, tick),
//   tdata the decoded ARP frame fields and the query address. Every item
//   gives exactly one rsp_* item: tuser carries the kind of frame to send,
//   tdata its target, the lookup result and an event code.
//   csr_* is a register port for local IP/MAC, the two timeouts and the
//   retry budget; write it only while no item is in flight.
// Path and throughput:
//   an accepted item is stored in the queue, taken from its head by the
//   back end and its result registered on rsp_*. One item per cycle is
//   sustained while rsp_tready is high, and each pop updates the entry.
// Stalls and reset:
//   a queue of QUEUE_DEPTH items sits between classifier and execution;
//   while rsp_tready is low the result is held and req_tready drops once
//   the queue is full. Reset empties the queue, drops any pending result,
//   frees the entry and loads the register defaults.
// ----------------------------------------------------------------------------
module arp_single_entry_resolver #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic         clock,
   input  logic         reset,
   // item input
   input  logic         req_tvalid,
   output logic         req_tready,
   // frame_length, hardware_type, protocol_type, hardware_len, protocol_len,
   // arp_opcode, src_mac, src_ip, dst_ip, query_ip, zero pad
   input  logic [223:0] req_tdata,
   // action
   input  logic [1:0]   req_tuser,
   // result output
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // send_dst_ip, send_dst_mac, lookup_hit, resolved_mac, event_res,
   // zero pad
   output logic [135:0] rsp_tdata,
   // send_kind
   output logic [1:0]   rsp_tuser,
   // register port
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [5:0]   csr_paddr,
   input  logic [63:0]  csr_pwdata,
   output logic [63:0]  csr_prdata,
   output logic         csr_pready
);
   import arpr_pkg::*;

   // registers
   logic [31:0] local_ip_ff;
   logic [47:0] local_mac_ff;
   logic [15:0] valid_to_ff;
   logic [15:0] pending_to_ff;
   logic [7:0]  max_retries_ff;
   logic        csr_wr;
   logic [2:0]  csr_index;

   item_type        front_item;
   item_type        head_item;
   logic            head_valid;
   logic            head_pop;
   timing_type      timing;
   back_status_type back_status;

   logic [1:0]  out_kind;
   logic [31:0] out_tip;
   logic [47:0] out_tmac;
   logic        out_hit;
   logic [47:0] out_rmac;
   logic [3:0]  out_event;

   // register port
   assign csr_pready = 1'b1;
   assign csr_index  = csr_paddr[5:3];
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         local_ip_ff    <= '0;
         local_mac_ff   <= '0;
         valid_to_ff    <= 16'd5;
         pending_to_ff  <= 16'd1;
         max_retries_ff <= 8'd5;
      end else if (csr_wr) begin
         case (csr_index)
            REG_LOCAL_IP:    local_ip_ff    <= csr_pwdata[31:0];
            REG_LOCAL_MAC:   local_mac_ff   <= csr_pwdata[47:0];
            REG_VALID_TO:    valid_to_ff    <= csr_pwdata[15:0];
            REG_PENDING_TO:  pending_to_ff  <= csr_pwdata[15:0];
            REG_MAX_RETRIES: max_retries_ff <= csr_pwdata[7:0];
            default: begin
            end
         endcase
      end
   end

   // register read back
   always_comb begin
      case (csr_index)
         REG_LOCAL_IP:    csr_prdata = {32'd0, local_ip_ff};
         REG_LOCAL_MAC:   csr_prdata = {16'd0, local_mac_ff};
         REG_VALID_TO:    csr_prdata = {48'd0, valid_to_ff};
         REG_PENDING_TO:  csr_prdata = {48'd0, pending_to_ff};
         REG_MAX_RETRIES: csr_prdata = {56'd0, max_retries_ff};
         default:         csr_prdata = '0;
      endcase
   end

   assign timing.valid_to    = valid_to_ff;
   assign timing.pending_to  = pending_to_ff;
   assign timing.max_retries = max_retries_ff;

   // front end: classification
   arpr_front u_front (
      .action        (req_tuser),
      .frame_length  (req_tdata[10:0]),
      .hardware_type (req_tdata[26:11]),
      .protocol_type (req_tdata[42:27]),
      .hardware_len  (req_tdata[50:43]),
      .protocol_len  (req_tdata[58:51]),
      .arp_opcode    (req_tdata[74:59]),
      .src_mac       (req_tdata[122:75]),
      .src_ip        (req_tdata[154:123]),
      .dst_ip        (req_tdata[186:155]),
      .query_ip      (req_tdata[218:187]),
      .local_ip      (local_ip_ff),
      .item          (front_item)
   );

   // queue between the two halves
   arpr_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (req_tvalid),
      .push_item  (front_item),
      .push_ready (req_tready),
      .pop        (head_pop),
      .pop_item   (head_item),
      .pop_valid  (head_valid)
   );

   // back end: entry update and result register
   arpr_back u_back (
      .clock            (clock),
      .reset            (reset),
      .item             (head_item),
      .item_valid       (head_valid),
      .item_pop         (head_pop),
      .timing           (timing),
      .rsp_valid        (rsp_tvalid),
      .rsp_ready        (rsp_tready),
      .rsp_kind         (out_kind),
      .rsp_dst_ip       (out_tip),
      .rsp_dst_mac      (out_tmac),
      .rsp_hit          (out_hit),
      .rsp_resolved_mac (out_rmac),
      .rsp_event        (out_event),
      .status           (back_status)
   );

   assign rsp_tuser = out_kind;
   assign rsp_tdata = {3'd0, out_event, out_rmac, out_hit, out_tmac, out_tip};

   // the local MAC is only read back; frame assembly lies outside this block

   // checks
   a_stall_only_when_busy: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> head_valid)
      else $error("input stalled with an empty queue");

   a_hit_needs_valid_entry: assert property (@(posedge clock) disable iff (reset)
      (back_status.pop && back_status.mode != MODE_VALID) |=> !rsp_tdata[80])
      else $error("lookup hit without a valid entry");

   a_reset_clears_output: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result valid right after reset");

endmodule

### test/arp_single_entry_resolver_test.sv
// ----------------------------------------------------------------------------
// arp_single_entry_resolver_test
// Self-checking bench for the single-entry ARP resolver. Frame, query and
// tick items go in with random gaps while the result side stalls at random.
// An in-bench cache predictor works out each result, and every result is
// compared field by field with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module arp_single_entry_resolver_test;
   import arpr_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int PRINT_LIMIT = 100;

   // action code that the block must treat as a quiet no-op
   localparam logic [1:0] ACT_UNUSED = 2'd3;
   // register slots with nothing behind them
   localparam logic [2:0] REG_UNUSED_LO = 3'd5;
   localparam logic [2:0] REG_UNUSED_HI = 3'd7;

   // req_tdata layout, lowest field last
   typedef struct packed {
      logic [4:0]  pad;
      logic [31:0] query_ip;
      logic [31:0] dst_ip;
      logic [31:0] src_ip;
      logic [47:0] src_mac;
      logic [15:0] arp_opcode;
      logic [7:0]  protocol_len;
      logic [7:0]  hardware_len;
      logic [15:0] protocol_type;
      logic [15:0] hardware_type;
      logic [10:0] frame_length;
   } arp_fields_type;

   // rsp_tdata layout, lowest field last
   typedef struct packed {
      logic [2:0]  pad;
      logic [3:0]  event_res;
      logic [47:0] resolved_mac;
      logic        lookup_hit;
      logic [47:0] send_dst_mac;
      logic [31:0] send_dst_ip;
   } arp_answer_type;

   typedef struct packed {
      logic [1:0]     send_kind;
      arp_answer_type answer;
   } arp_outcome_type;

   logic         clock;
   logic         reset       = 1'b1;
   logic         req_tvalid  = 1'b0;
   logic         req_tready;
   // frame_length, hardware_type, protocol_type, hardware_len, protocol_len,
   // arp_opcode, src_mac, src_ip, dst_ip, query_ip, zero pad
   logic [223:0] req_tdata   = '0;
   // action
   logic [1:0]   req_tuser   = ACT_TICK;
   logic         rsp_tvalid;
   logic         rsp_tready  = 1'b0;
   // send_dst_ip, send_dst_mac, lookup_hit, resolved_mac, event_res,
   // zero pad
   logic [135:0] rsp_tdata;
   // send_kind
   logic [1:0]   rsp_tuser;
   logic         csr_psel    = 1'b0;
   logic         csr_penable = 1'b0;
   logic         csr_pwrite  = 1'b0;
   logic [5:0]   csr_paddr   = '0;
   logic [63:0]  csr_pwdata  = '0;
   logic [63:0]  csr_prdata;
   logic         csr_pready;

   // predictor copy of the registers and the cache entry
   logic [31:0] cfg_local_ip;
   logic [47:0] cfg_local_mac;
   logic [15:0] cfg_valid_to;
   logic [15:0] cfg_pending_to;
   logic [7:0]  cfg_max_retries;
   mode_type    cache_mode;
   logic [31:0] cache_ip;
   logic [47:0] cache_mac;
   logic [15:0] cache_ticks;
   logic [7:0]  cache_retries;

   arp_outcome_type pending_outcomes[$];
   int              error_count = 0;
   bit              steady_flow = 1'b0;
   logic [31:0]     ip_pool[4];

   arp_single_entry_resolver u_top (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // run limit
   initial begin
      int cycle_count;
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("tb: failure");
      $finish;
   end

   // register defaults and a free entry, as after reset
   initial begin
      cfg_local_ip    = '0;
      cfg_local_mac   = '0;
      cfg_valid_to    = 16'd5;
      cfg_pending_to  = 16'd1;
      cfg_max_retries = 8'd5;
      cache_mode      = MODE_FREE;
      cache_ip        = '0;
      cache_mac       = '0;
      cache_ticks     = '0;
      cache_retries   = '0;
   end

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      // keep the log short when the block is badly broken
      if (error_count < PRINT_LIMIT)
         $display("mismatch: %s got %h want %h", what, got, want);
      error_count++;
   endtask

   // one tick of countdown, true when the entry times out
   function automatic bit tick_expires();
      if (cache_ticks <= 16'd1) begin
         cache_ticks = '0;
         return 1'b1;
      end
      cache_ticks = cache_ticks - 16'd1;
      return 1'b0;
   endfunction

   // expected result of one item, updating the cache copy
   function automatic arp_outcome_type predict_outcome(logic [1:0] act, arp_fields_type f);
      arp_outcome_type o;
      o = '0;
      o.send_kind = KIND_NONE;
      o.answer.event_res = EV_QUIET;
      case (act)
         ACT_FRAME: begin
            if (f.frame_length < MIN_FRAME_LEN) begin
               o.answer.event_res = EV_SHORT;
            end else if (f.hardware_type != HTYPE_ETH || f.protocol_type != PTYPE_IPV4 ||
                         f.hardware_len != HLEN_ETH || f.protocol_len != PLEN_IPV4 ||
                         (f.arp_opcode != ARP_OP_REQ && f.arp_opcode != ARP_OP_REP)) begin
               o.answer.event_res = EV_MALFORMED;
            end else if (f.dst_ip != cfg_local_ip) begin
               o.answer.event_res = EV_NOT_US;
            end else begin
               cache_ip      = f.src_ip;
               cache_mac     = f.src_mac;
               cache_mode    = MODE_VALID;
               cache_ticks   = cfg_valid_to;
               cache_retries = cfg_max_retries;
               if (f.arp_opcode == ARP_OP_REQ) begin
                  o.send_kind = KIND_REPLY;
                  o.answer.send_dst_ip = f.src_ip;
                  o.answer.send_dst_mac = f.src_mac;
                  o.answer.event_res = EV_LEARN_REQ;
               end else begin
                  o.answer.event_res = EV_LEARN_REP;
               end
            end
         end
         ACT_QUERY: begin
            if (cache_mode == MODE_VALID && cache_ip == f.query_ip) begin
               o.answer.lookup_hit = 1'b1;
               o.answer.resolved_mac = cache_mac;
               o.answer.event_res = EV_HIT;
            end else begin
               o.send_kind = KIND_BCAST;
               o.answer.send_dst_ip = f.query_ip;
               o.answer.event_res = EV_MISS;
            end
         end
         ACT_TICK: begin
            if (cache_mode == MODE_VALID) begin
               if (tick_expires()) begin
                  o.send_kind = KIND_BCAST;
                  o.answer.send_dst_ip = cache_ip;
                  o.answer.event_res = EV_EXPIRED;
                  cache_mode = MODE_PENDING;
                  cache_ticks = cfg_pending_to;
               end
            end else if (cache_mode == MODE_PENDING) begin
               if (tick_expires()) begin
                  if (cache_retries == '0) begin
                     // retry budget used up: entry is freed, no frame is sent
                     cache_mode = MODE_FREE;
                     o.answer.event_res = EV_FREED;
                  end else begin
                     cache_retries = cache_retries - 8'd1;
                     o.send_kind = KIND_BCAST;
                     o.answer.send_dst_ip = cache_ip;
                     o.answer.event_res = EV_RETRY;
                     cache_ticks = cfg_pending_to;
                  end
               end
            end
         end
         default: ;
      endcase
      return o;
   endfunction

   // monitor: check results, predict accepted items, track register writes
   always @(posedge clock) begin
      arp_outcome_type want;
      arp_answer_type  got;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata;
            if (pending_outcomes.size() == 0) begin
               report_mismatch("result with nothing outstanding", 64'(rsp_tuser),
                               64'(got.event_res));
            end else begin
               want = pending_outcomes.pop_front();
               if (rsp_tuser != want.send_kind)
                  report_mismatch("send_kind", 64'(rsp_tuser), 64'(want.send_kind));
               if (got.send_dst_ip != want.answer.send_dst_ip)
                  report_mismatch("send_dst_ip", 64'(got.send_dst_ip),
                                  64'(want.answer.send_dst_ip));
               if (got.send_dst_mac != want.answer.send_dst_mac)
                  report_mismatch("send_dst_mac", 64'(got.send_dst_mac),
                                  64'(want.answer.send_dst_mac));
               if (got.lookup_hit != want.answer.lookup_hit)
                  report_mismatch("lookup_hit", 64'(got.lookup_hit),
                                  64'(want.answer.lookup_hit));
               if (got.resolved_mac != want.answer.resolved_mac)
                  report_mismatch("resolved_mac", 64'(got.resolved_mac),
                                  64'(want.answer.resolved_mac));
               if (got.event_res != want.answer.event_res)
                  report_mismatch("event_res", 64'(got.event_res),
                                  64'(want.answer.event_res));
            end
         end
         if (req_tvalid && req_tready)
            pending_outcomes.push_back(predict_outcome(req_tuser,
                                                       arp_fields_type'(req_tdata)));
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_paddr[5:3])
               REG_LOCAL_IP:    cfg_local_ip    = csr_pwdata[31:0];
               REG_LOCAL_MAC:   cfg_local_mac   = csr_pwdata[47:0];
               REG_VALID_TO:    cfg_valid_to    = csr_pwdata[15:0];
               REG_PENDING_TO:  cfg_pending_to  = csr_pwdata[15:0];
               REG_MAX_RETRIES: cfg_max_retries = csr_pwdata[7:0];
               default: ;
            endcase
         end
      end
   end

   // result side stalls in random bursts
   initial begin
      forever begin
         if (!steady_flow && $urandom_range(0, 3) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
   end

   // send one item, with an optional idle burst ahead of it
   task automatic send_item(logic [1:0] act, arp_fields_type f);
      if (!steady_flow && $urandom_range(0, 4) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= act;
      req_tdata  <= f;
      do @(posedge clock); while (!req_tready);
   endtask

   // stop sending and wait until every result is back
   task automatic drain_block();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_outcomes.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   // register write: setup, then access until csr_pready, then idle
   task automatic write_register(logic [2:0] index, logic [63:0] value);
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr   <= {index, 3'b000};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   function automatic arp_fields_type random_fields();
      arp_fields_type f;
      f = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
      f.pad = '0;
      return f;
   endfunction

   // well-formed frame with random unused fields
   function automatic arp_fields_type good_frame(logic [15:0] op, logic [31:0] sip,
                                                 logic [47:0] smac, logic [31:0] tip);
      arp_fields_type f;
      f = random_fields();
      f.frame_length  = 11'($urandom_range(28, 80));
      f.hardware_type = HTYPE_ETH;
      f.protocol_type = PTYPE_IPV4;
      f.hardware_len  = HLEN_ETH;
      f.protocol_len  = PLEN_IPV4;
      f.arp_opcode    = op;
      f.src_ip        = sip;
      f.src_mac       = smac;
      f.dst_ip        = tip;
      return f;
   endfunction

   function automatic arp_fields_type query_for(logic [31:0] ip);
      arp_fields_type f;
      f = random_fields();
      f.query_ip = ip;
      return f;
   endfunction

   // extremes and every event under the reset register values
   task automatic test_directed_defaults();
      arp_fields_type f;
      logic [31:0]    ip_a;
      logic [31:0]    ip_b;
      ip_a = $urandom;
      ip_b = ip_a ^ 32'h8000_0001;
      send_item(ACT_TICK, random_fields());
      // a query for ip zero on a free entry must still miss
      send_item(ACT_QUERY, query_for('0));
      f = good_frame(ARP_OP_REQ, ip_a, 48'($urandom), '0);
      f.frame_length = '0;
      send_item(ACT_FRAME, f);
      f.frame_length = 11'd27;
      send_item(ACT_FRAME, f);
      // each header check on its own
      f = good_frame(ARP_OP_REQ, ip_a, 48'($urandom), '0);
      f.hardware_type = '0;
      send_item(ACT_FRAME, f);
      f = good_frame(ARP_OP_REQ, ip_a, 48'($urandom), '0);
      f.protocol_type = 16'h0806;
      send_item(ACT_FRAME, f);
      f = good_frame(ARP_OP_REQ, ip_a, 48'($urandom), '0);
      f.hardware_len = 8'hff;
      send_item(ACT_FRAME, f);
      f = good_frame(ARP_OP_REQ, ip_a, 48'($urandom), '0);
      f.protocol_len = '0;
      send_item(ACT_FRAME, f);
      send_item(ACT_FRAME, good_frame(16'd0, ip_a, 48'($urandom), '0));
      send_item(ACT_FRAME, good_frame(16'd3, ip_a, 48'($urandom), '0));
      send_item(ACT_FRAME, good_frame(16'hffff, ip_a, 48'($urandom), '0));
      send_item(ACT_FRAME, good_frame(ARP_OP_REQ, ip_a, 48'($urandom), 32'hffff_ffff));
      // learn by request, shortest legal frame
      f = good_frame(ARP_OP_REQ, ip_a, 48'hffff_ffff_ffff, '0);
      f.frame_length = MIN_FRAME_LEN;
      send_item(ACT_FRAME, f);
      send_item(ACT_QUERY, query_for(ip_a));
      send_item(ACT_QUERY, query_for(ip_b));
      // learn by reply, longest frame
      f = good_frame(ARP_OP_REP, ip_b, '0, '0);
      f.frame_length = 11'h7ff;
      send_item(ACT_FRAME, f);
      send_item(ACT_QUERY, query_for(ip_b));
      send_item(ACT_UNUSED, random_fields());
      // age out: valid, expired, retries, freed
      repeat (5) send_item(ACT_TICK, random_fields());
      send_item(ACT_QUERY, query_for(ip_b));
      repeat (7) send_item(ACT_TICK, random_fields());
   endtask

   // registers at their extremes, unused slots and zero timeouts
   task automatic test_register_extremes();
      logic [31:0] ip_a;
      ip_a = $urandom;
      drain_block();
      write_register(REG_LOCAL_IP, 64'hffff_ffff_ffff_ffff);
      write_register(REG_LOCAL_MAC, 64'hffff_ffff_ffff_ffff);
      write_register(REG_VALID_TO, 64'hffff_ffff_ffff_ffff);
      write_register(REG_PENDING_TO, 64'hffff_ffff_ffff_ffff);
      write_register(REG_MAX_RETRIES, 64'hffff_ffff_ffff_ffff);
      write_register(REG_UNUSED_LO, 64'hffff_ffff_ffff_ffff);
      write_register(REG_UNUSED_HI, '0);
      send_item(ACT_FRAME, good_frame(ARP_OP_REQ, ip_a, 48'($urandom), 32'hffff_ffff));
      send_item(ACT_FRAME, good_frame(ARP_OP_REP, ip_a, 48'($urandom), '0));
      repeat (3) send_item(ACT_TICK, random_fields());
      send_item(ACT_QUERY, query_for(ip_a));
      drain_block();
      // a zero timeout acts as one tick, zero retries frees at once
      write_register(REG_LOCAL_IP, '0);
      write_register(REG_LOCAL_MAC, '0);
      write_register(REG_VALID_TO, '0);
      write_register(REG_PENDING_TO, '0);
      write_register(REG_MAX_RETRIES, '0);
      send_item(ACT_FRAME, good_frame(ARP_OP_REP, ip_a, 48'($urandom), '0));
      send_item(ACT_QUERY, query_for(ip_a));
      repeat (3) send_item(ACT_TICK, random_fields());
      send_item(ACT_QUERY, query_for(ip_a));
   endtask

   // random traffic in phases, each with its own settings
   task automatic test_random_traffic();
      arp_fields_type f;
      int             frame_pct;
      int             pick;
      logic [15:0]    op;
      for (int phase = 0; phase < 7; phase++) begin
         drain_block();
         write_register(REG_LOCAL_IP, {32'($urandom), 32'($urandom)});
         write_register(REG_LOCAL_MAC, {32'($urandom), 32'($urandom)});
         write_register(REG_VALID_TO, 64'($urandom_range(0, 6)));
         write_register(REG_PENDING_TO, 64'($urandom_range(0, 3)));
         write_register(REG_MAX_RETRIES, 64'($urandom_range(0, 3)));
         foreach (ip_pool[i]) ip_pool[i] = $urandom;
         frame_pct = $urandom_range(4, 20);
         // last phase runs with no idling on either side
         steady_flow = (phase == 6);
         repeat (250) begin
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
               send_item(ACT_TICK, random_fields());
            end else if (pick < 70) begin
               if ($urandom_range(0, 2) != 0)
                  send_item(ACT_QUERY, query_for(ip_pool[$urandom_range(0, 3)]));
               else
                  send_item(ACT_QUERY, query_for($urandom));
            end else if (pick < 70 + frame_pct) begin
               op = $urandom_range(0, 1) ? ARP_OP_REQ : ARP_OP_REP;
               f = good_frame(op, ip_pool[$urandom_range(0, 3)], 48'({$urandom, $urandom}),
                              ($urandom_range(0, 9) != 0) ? cfg_local_ip : $urandom);
               send_item(ACT_FRAME, f);
            end else if (pick < 85 + frame_pct / 2) begin
               // otherwise good frame broken in one place
               f = good_frame(ARP_OP_REQ, ip_pool[$urandom_range(0, 3)], 48'($urandom),
                              cfg_local_ip);
               case ($urandom_range(0, 5))
                  0: f.frame_length  = 11'($urandom_range(0, 27));
                  1: f.hardware_type = 16'($urandom);
                  2: f.protocol_type = 16'($urandom);
                  3: f.hardware_len  = 8'($urandom);
                  4: f.protocol_len  = 8'($urandom);
                  default: f.arp_opcode = 16'($urandom);
               endcase
               send_item(ACT_FRAME, f);
            end else begin
               send_item(2'($urandom_range(0, 3)), random_fields());
            end
         end
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_defaults();
      test_register_extremes();
      test_random_traffic();
      drain_block();
      repeat (10) @(posedge clock);
      if (error_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule

### sim.f
rtl/core/arpr_pkg.sv
rtl/core/arpr_front.sv
rtl/core/arpr_queue.sv
rtl/core/arpr_back.sv
rtl/core/arp_single_entry_resolver.sv
test/arp_single_entry_resolver_test.sv
